@@ rtl/mst_pkg.sv @@
package mst_pkg;

  // Default parameter values
  localparam int ANGLE_BITS_DEF      = 12;
  localparam int SPEED_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int POS_W   = 32;
  localparam int SPEED_W = 44;
  localparam int RATE_W  = 16;
  localparam int GAIN_W  = 17;

  // Shared multiplier: signed MUL_A_W x signed MUL_B_W
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Filter error x - speed, split in two halves for the multiplier
  localparam int DIFF_W  = SPEED_W + 1;
  localparam int D_LO_W  = 22;
  localparam int D_HI_W  = DIFF_W - D_LO_W;

  localparam int ACC_W      = 64;
  localparam int GAIN_SHIFT = 16;
  localparam int UPD_W      = ACC_W - GAIN_SHIFT;
  localparam int SUM_W      = UPD_W + 1;

  localparam logic signed [ACC_W-1:0] SPD_MAX    = ACC_W'((64'sd1 <<< (SPEED_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SPD_MIN    = -SPD_MAX - 64'sd1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (GAIN_SHIFT - 1));

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32768);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(4000);

  // APB register map, one 32-bit word per register
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ANGLE_OFFSET = 2'd0,
    REG_SAMPLE_RATE  = 2'd1,
    REG_FILTER_GAIN  = 2'd2
  } reg_idx_e;

endpackage

@@ rtl/multiturn_angle_speed_tracker.sv @@
// Multi-turn angle and speed tracker. Each item is one raw angle sample; the
// block adds angle_offset (modulo 2^ANGLE_BITS), unwraps the step against the
// previous angle, accumulates a 32-bit wrapping position and low-pass filters
// step*sample_rate_hz into a signed 44-bit speed with SPEED_FRAC_BITS fraction
// bits (speed += gain*(x - speed), gain in 1/65536, rounded to nearest). The
// first sample after reset only seeds the angle and returns a zero step with
// primed low. Timing: a sample is accepted only while the sequencer is idle;
// a primed sample runs STEP, MULX, SATX, MULLO, MULHI, ACC, UPD, DONE before
// its result is registered, a first sample only STEP and DONE; the next sample
// waits for idle. One shared 24x18 signed multiplier is used three times per
// sample (step*rate, then the low and high halves of the filter error times
// gain), followed by separate accumulate and saturate steps. A finished result
// waits in the output register; the next sample can be taken meanwhile, and the
// block only holds in its last step if the previous result is still untaken.
// Registers (APB, 32-bit words): 0x0 angle_offset, 0x4 sample_rate_hz,
// 0x8 filter_gain (values above 65536 act as 65536).
module multiturn_angle_speed_tracker #(
  parameter int ANGLE_BITS      = mst_pkg::ANGLE_BITS_DEF,
  parameter int SPEED_FRAC_BITS = mst_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mst_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [mst_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [mst_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,

  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ANGLE_BITS-1:0]                  raw_angle_i,

  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [ANGLE_BITS-1:0]                  rotor_angle_o,
  output logic signed [ANGLE_BITS:0]             angle_step_o,
  output logic signed [mst_pkg::POS_W-1:0]       position_o,
  output logic signed [mst_pkg::SPEED_W-1:0]     speed_o,
  output logic                                   primed_o
);

  localparam int MulAW  = mst_pkg::MUL_A_W;
  localparam int MulBW  = mst_pkg::MUL_B_W;
  localparam int MulPW  = mst_pkg::MUL_P_W;
  localparam int DiffW  = mst_pkg::DIFF_W;
  localparam int DLoW   = mst_pkg::D_LO_W;
  localparam int AccW   = mst_pkg::ACC_W;
  localparam int UpdW   = mst_pkg::UPD_W;
  localparam int SumW   = mst_pkg::SUM_W;
  localparam int SpeedW = mst_pkg::SPEED_W;
  localparam int PosW   = mst_pkg::POS_W;
  localparam int RateW  = mst_pkg::RATE_W;
  localparam int GainW  = mst_pkg::GAIN_W;
  localparam int DataW  = mst_pkg::APB_DATA_W;
  localparam int StepW  = ANGLE_BITS + 1;
  localparam int DiffAW = ANGLE_BITS + 2;

  localparam logic signed [DiffAW-1:0] AngHalf = DiffAW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [DiffAW-1:0] AngFull = DiffAW'(1) <<< ANGLE_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_MULX,
    S_SATX,
    S_MULLO,
    S_MULHI,
    S_ACC,
    S_UPD,
    S_DONE
  } state_e;

  state_e                      state_q;

  logic [ANGLE_BITS-1:0]       angle_offset_q;
  logic [RateW-1:0]            sample_rate_q;
  logic [GainW-1:0]            filter_gain_q;

  logic                        has_prev_q;
  logic                        primed_q;
  logic [ANGLE_BITS-1:0]       angle_q;
  logic [ANGLE_BITS-1:0]       last_angle_q;
  logic signed [StepW-1:0]     step_q;
  logic signed [PosW-1:0]      pos_q;
  logic signed [SpeedW-1:0]    speed_q;
  logic signed [MulPW-1:0]     mul_q;
  logic signed [DiffW-1:0]     diff_q;
  logic signed [AccW-1:0]      acc_q;
  logic                        out_valid_q;

  logic signed [DiffAW-1:0]    raw_diff;
  logic signed [DiffAW-1:0]    unwrap;
  logic signed [StepW-1:0]     step_d;
  logic [GainW-1:0]            gain_sat;
  logic signed [MulAW-1:0]     mul_a;
  logic signed [MulBW-1:0]     mul_b;
  logic signed [MulPW-1:0]     mul_p;
  logic signed [AccW-1:0]      x_wide;
  logic signed [SpeedW-1:0]    x_sat;
  logic signed [DiffW-1:0]     diff_d;
  logic signed [AccW-1:0]      acc_d;
  logic signed [UpdW-1:0]      upd;
  logic signed [SumW-1:0]      spd_sum;
  logic signed [SpeedW-1:0]    speed_d;
  logic                        apb_wr;
  logic                        out_free;

  assign pready      = 1'b1;
  assign apb_wr      = psel & penable & pwrite;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      mst_pkg::REG_ANGLE_OFFSET: prdata = DataW'(angle_offset_q);
      mst_pkg::REG_SAMPLE_RATE:  prdata = DataW'(sample_rate_q);
      mst_pkg::REG_FILTER_GAIN:  prdata = DataW'(filter_gain_q);
      default:                   prdata = '0;
    endcase
  end

  // Unwrap into -half..+half; exactly -half and +half pass unchanged
  always_comb begin
    raw_diff = $signed({2'b00, angle_q}) - $signed({2'b00, last_angle_q});
    unwrap   = raw_diff;
    if (raw_diff > AngHalf) begin
      unwrap = raw_diff - AngFull;
    end else if (raw_diff < -AngHalf) begin
      unwrap = raw_diff + AngFull;
    end
    step_d = unwrap[StepW-1:0];
  end

  assign gain_sat = (filter_gain_q > mst_pkg::GAIN_ONE) ? mst_pkg::GAIN_ONE : filter_gain_q;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MULX: begin
        mul_a = MulAW'(step_q);
        mul_b = $signed(MulBW'(sample_rate_q));
      end
      S_MULLO: begin
        mul_a = $signed(MulAW'(diff_q[DLoW-1:0]));
        mul_b = $signed(MulBW'(gain_sat));
      end
      S_MULHI: begin
        mul_a = MulAW'($signed(diff_q[DiffW-1:DLoW]));
        mul_b = $signed(MulBW'(gain_sat));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

  // Raw speed, saturated, and the filter error
  always_comb begin
    x_wide = AccW'(mul_q) <<< SPEED_FRAC_BITS;
    if (x_wide > mst_pkg::SPD_MAX) begin
      x_sat = SpeedW'(mst_pkg::SPD_MAX);
    end else if (x_wide < mst_pkg::SPD_MIN) begin
      x_sat = SpeedW'(mst_pkg::SPD_MIN);
    end else begin
      x_sat = x_wide[SpeedW-1:0];
    end
    diff_d = DiffW'(x_sat) - DiffW'(speed_q);
  end

  // Combine high partial product with low one (rounding already added)
  assign acc_d = acc_q + (AccW'(mul_q) <<< DLoW);

  always_comb begin
    upd     = acc_q[AccW-1:mst_pkg::GAIN_SHIFT];
    spd_sum = SumW'(speed_q) + SumW'(upd);
    if (SumW'(spd_sum) > SumW'(mst_pkg::SPD_MAX)) begin
      speed_d = SpeedW'(mst_pkg::SPD_MAX);
    end else if (spd_sum < SumW'(mst_pkg::SPD_MIN)) begin
      speed_d = SpeedW'(mst_pkg::SPD_MIN);
    end else begin
      speed_d = spd_sum[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      angle_offset_q <= '0;
      sample_rate_q  <= mst_pkg::RATE_RESET;
      filter_gain_q  <= mst_pkg::GAIN_RESET;
      has_prev_q     <= 1'b0;
      primed_q       <= 1'b0;
      angle_q        <= '0;
      last_angle_q   <= '0;
      step_q         <= '0;
      pos_q          <= '0;
      speed_q        <= '0;
      mul_q          <= '0;
      diff_q         <= '0;
      acc_q          <= '0;
      out_valid_q    <= 1'b0;
      rotor_angle_o  <= '0;
      angle_step_o   <= '0;
      position_o     <= '0;
      speed_o        <= '0;
      primed_o       <= 1'b0;
    end else begin
      if (apb_wr) begin
        unique case (paddr[3:2])
          mst_pkg::REG_ANGLE_OFFSET: angle_offset_q <= pwdata[ANGLE_BITS-1:0];
          mst_pkg::REG_SAMPLE_RATE:  sample_rate_q  <= pwdata[RateW-1:0];
          mst_pkg::REG_FILTER_GAIN:  filter_gain_q  <= pwdata[GainW-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless the next one is loaded below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            angle_q  <= raw_angle_i + angle_offset_q;
            primed_q <= has_prev_q;
            state_q  <= S_STEP;
          end
        end
        S_STEP: begin
          last_angle_q <= angle_q;
          if (has_prev_q) begin
            step_q  <= step_d;
            pos_q   <= pos_q + PosW'(step_d);
            state_q <= S_MULX;
          end else begin
            step_q     <= '0;
            has_prev_q <= 1'b1;
            state_q    <= S_DONE;
          end
        end
        S_MULX: begin
          mul_q   <= mul_p;
          state_q <= S_SATX;
        end
        S_SATX: begin
          diff_q  <= diff_d;
          state_q <= S_MULLO;
        end
        S_MULLO: begin
          mul_q   <= mul_p;
          state_q <= S_MULHI;
        end
        S_MULHI: begin
          acc_q   <= AccW'(mul_q) + mst_pkg::ROUND_HALF;
          mul_q   <= mul_p;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_d;
          state_q <= S_UPD;
        end
        S_UPD: begin
          speed_q <= speed_d;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rotor_angle_o <= angle_q;
            angle_step_o  <= step_q;
            position_o    <= pos_q;
            speed_o       <= speed_q;
            primed_o      <= primed_q;
            out_valid_q   <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
